### rtl/core/ros_pkg.sv
package ros_pkg;

   // Register indexes on the configuration port
   localparam logic [2:0] CSR_BOX_CENTER   = 3'd0;
   localparam logic [2:0] CSR_BOX_AXIS_U   = 3'd1;
   localparam logic [2:0] CSR_BOX_AXIS_V   = 3'd2;
   localparam logic [2:0] CSR_BOX_AXIS_W   = 3'd3;
   localparam logic [2:0] CSR_BOX_HALF_EXT = 3'd4;

   localparam logic [47:0] AXIS_U_RESET = 48'h0000_0000_4000;
   localparam logic [47:0] AXIS_V_RESET = 48'h0000_4000_0000;
   localparam logic [47:0] AXIS_W_RESET = 48'h4000_0000_0000;

   // Widths of the projected values
   localparam int P_W   = 35;   // position projection, units 2^-22
   localparam int D_W   = 34;   // direction projection, units 2^-28
   localparam int NUM_W = 36;   // slab numerator magnitude

   // Divider pipeline: 32 quotient bits, a few bits per stage
   localparam int DIV_STEPS   = 2;
   localparam int DIV_STAGES  = 32 / DIV_STEPS;
   localparam int DIV_LATENCY = DIV_STAGES + 2;
   localparam int FRONT_REGS  = 4;
   localparam int BACK_REGS   = 5;
   localparam int TOTAL_LAT   = FRONT_REGS + DIV_LATENCY + BACK_REGS;

   localparam logic [31:0] T_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] T_MIN = 32'h8000_0000;

   typedef struct packed {
      logic             neg;
      logic [NUM_W-1:0] num_mag;
      logic [D_W-1:0]   den_mag;
   } div_req_type;

   // Item state carried alongside the divider and through the clip stages
   typedef struct packed {
      logic                valid;
      logic signed [31:0]  t_start;
      logic signed [31:0]  t_end;
      logic [2:0]          dzero;
      logic [2:0]          outside;
   } line_type;

   typedef struct packed {
      logic                valid;
      logic                hit;
      logic signed [31:0]  tn;
      logic signed [31:0]  tf;
      logic [2:0]          dzero;
      logic [2:0]          outside;
      logic [2:0][31:0]    lo;
      logic [2:0][31:0]    hi;
   } clip_type;

   function automatic logic signed [15:0] fld(input logic [47:0] r, input int k);
      return r[16*k +: 16];
   endfunction

endpackage

### rtl/core/ros_div.sv
module ros_div (
   input  logic                 clock,
   input  ros_pkg::div_req_type req,
   output logic signed [31:0]   quot
);
   import ros_pkg::*;

   logic [D_W-1:0]  rem_ff [0:DIV_STAGES];
   logic [31:0]     low_ff [0:DIV_STAGES];
   logic [31:0]     quo_ff [0:DIV_STAGES];
   logic [D_W-1:0]  den_ff [0:DIV_STAGES];
   logic            neg_ff [0:DIV_STAGES];
   logic            ovf_ff [0:DIV_STAGES];
   logic [D_W-1:0]  rem_in [1:DIV_STAGES];
   logic [31:0]     low_in [1:DIV_STAGES];
   logic [31:0]     quo_in [1:DIV_STAGES];
   logic signed [31:0] quot_ff;

   // Load the high part of the dividend; a quotient of 2^32 or more saturates
   always_ff @(posedge clock) begin
      rem_ff[0] <= D_W'(req.num_mag[NUM_W-1:10]);
      low_ff[0] <= {req.num_mag[9:0], 22'd0};
      quo_ff[0] <= '0;
      den_ff[0] <= req.den_mag;
      neg_ff[0] <= req.neg;
      ovf_ff[0] <= D_W'(req.num_mag[NUM_W-1:10]) >= req.den_mag;
   end

   // Restoring division, a few quotient bits per stage
   for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_stage
      always_comb begin
         logic [D_W:0]   t;
         logic [D_W-1:0] r;
         logic [31:0]    l;
         logic [31:0]    q;
         r = rem_ff[j-1];
         l = low_ff[j-1];
         q = quo_ff[j-1];
         for (int s = 0; s < DIV_STEPS; s++) begin
            t = {r, l[31]};
            l = {l[30:0], 1'b0};
            if (t >= {1'b0, den_ff[j-1]}) begin
               t = t - {1'b0, den_ff[j-1]};
               q = {q[30:0], 1'b1};
            end else begin
               q = {q[30:0], 1'b0};
            end
            r = t[D_W-1:0];
         end
         rem_in[j] = r;
         low_in[j] = l;
         quo_in[j] = q;
      end

      always_ff @(posedge clock) begin
         rem_ff[j] <= rem_in[j];
         low_ff[j] <= low_in[j];
         quo_ff[j] <= quo_in[j];
         den_ff[j] <= den_ff[j-1];
         neg_ff[j] <= neg_ff[j-1];
         ovf_ff[j] <= ovf_ff[j-1];
      end
   end

   // Apply the sign and saturate to the Q16.16 range
   always_ff @(posedge clock) begin
      if (ovf_ff[DIV_STAGES]) begin
         quot_ff <= neg_ff[DIV_STAGES] ? T_MIN : T_MAX;
      end else if (neg_ff[DIV_STAGES]) begin
         quot_ff <= (quo_ff[DIV_STAGES] > T_MIN) ? T_MIN : -quo_ff[DIV_STAGES];
      end else begin
         quot_ff <= quo_ff[DIV_STAGES][31] ? T_MAX : quo_ff[DIV_STAGES];
      end
   end

   assign quot = quot_ff;

endmodule

### rtl/core/ray_obb_slab_intersect_top.sv
// Ray against oriented box, slab test.
// Input channel: drive the req_ ports and raise start; an item is taken at
// each rising edge with start high and busy low. busy stays low, so an item
// may enter in every cycle.
// Configuration: write box center, the three axes and the half extents on
// the csr_ channel (valid/ready, ready always high) while no item is in flight.
// Result channel: one result per item, shown for one cycle with rsp_valid.
// Throughput is one item per cycle. The pipeline is built around the
// pipelined restoring dividers: 32 quotient bits at two bits per stage,
// plus projection stages in front and three clip stages (one per axis)
// behind them.
// Reset clears all valid bits and loads the default configuration (unit
// axes, center and half extents zero). The receiver cannot stall the block;
// results leave in input order.
module ray_obb_slab_intersect_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [15:0] req_origin_x,
   input  logic signed [15:0] req_origin_y,
   input  logic signed [15:0] req_origin_z,
   input  logic signed [15:0] req_direction_x,
   input  logic signed [15:0] req_direction_y,
   input  logic signed [15:0] req_direction_z,
   input  logic signed [31:0] req_t_start,
   input  logic signed [31:0] req_t_end,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_t_enter,
   output logic signed [31:0] rsp_t_exit,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_wdata
);
   import ros_pkg::*;

   logic [47:0] center_ff, axis_u_ff, axis_v_ff, axis_w_ff, half_ff;
   logic [47:0] axis_sel [3];
   logic signed [15:0] org [3];
   logic signed [15:0] dir [3];

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [16:0] rel_ff [3];
   logic signed [15:0] dir_ff [3];
   logic signed [31:0] ts1_ff, te1_ff, ts2_ff, te2_ff, ts3_ff, te3_ff, ts4_ff, te4_ff;
   logic signed [32:0] pp_ff [3][3];
   logic signed [31:0] dp_ff [3][3];
   logic signed [P_W-1:0] p_ff [3];
   logic signed [D_W-1:0] d_ff [3];
   div_req_type        req_ff [3][2];
   div_req_type        req_in [3][2];
   logic [2:0]         dz_ff, out_ff, dz_in, out_in;
   logic signed [31:0] quot [3][2];
   line_type           line_ff [DIV_LATENCY];
   clip_type           st_ff [4];
   clip_type           st_in [1:3];
   logic               rsp_valid_ff, rsp_hit_ff;
   logic signed [31:0] rsp_tn_ff, rsp_tf_ff;
   logic               accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   assign axis_sel[0] = axis_u_ff;
   assign axis_sel[1] = axis_v_ff;
   assign axis_sel[2] = axis_w_ff;
   assign org[0] = req_origin_x;
   assign org[1] = req_origin_y;
   assign org[2] = req_origin_z;
   assign dir[0] = req_direction_x;
   assign dir[1] = req_direction_y;
   assign dir[2] = req_direction_z;

   // Take configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         axis_u_ff <= AXIS_U_RESET;
         axis_v_ff <= AXIS_V_RESET;
         axis_w_ff <= AXIS_W_RESET;
         half_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BOX_CENTER:   center_ff <= csr_wdata;
            CSR_BOX_AXIS_U:   axis_u_ff <= csr_wdata;
            CSR_BOX_AXIS_V:   axis_v_ff <= csr_wdata;
            CSR_BOX_AXIS_W:   axis_w_ff <= csr_wdata;
            CSR_BOX_HALF_EXT: half_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Valid bits of the front stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Stage 1: origin relative to the center
   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         rel_ff[k] <= 17'(org[k]) - 17'(fld(center_ff, k));
         dir_ff[k] <= dir[k];
      end
      ts1_ff <= req_t_start;
      te1_ff <= req_t_end;
   end

   // Stage 2: axis component products
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 3; k++) begin
            pp_ff[a][k] <= fld(axis_sel[a], k) * rel_ff[k];
            dp_ff[a][k] <= fld(axis_sel[a], k) * dir_ff[k];
         end
      end
      ts2_ff <= ts1_ff;
      te2_ff <= te1_ff;
   end

   // Stage 3: projections
   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         p_ff[a] <= P_W'(pp_ff[a][0]) + P_W'(pp_ff[a][1]) + P_W'(pp_ff[a][2]);
         d_ff[a] <= D_W'(dp_ff[a][0]) + D_W'(dp_ff[a][1]) + D_W'(dp_ff[a][2]);
      end
      ts3_ff <= ts2_ff;
      te3_ff <= te2_ff;
   end

   // Stage 4: slab numerators, signs and magnitudes for the dividers
   always_comb begin
      logic signed [NUM_W-1:0] hs, ps, n1, n2;
      logic [D_W-1:0]          dmag;
      for (int a = 0; a < 3; a++) begin
         hs   = signed'({6'd0, half_ff[16*a +: 16], 14'd0});
         ps   = NUM_W'(p_ff[a]);
         n1   = -hs - ps;
         n2   = hs - ps;
         dmag = d_ff[a][D_W-1] ? D_W'(-d_ff[a]) : D_W'(d_ff[a]);
         dz_in[a]  = (d_ff[a] == '0);
         out_in[a] = (ps < -hs) || (ps > hs);
         req_in[a][0].neg     = n1[NUM_W-1] ^ d_ff[a][D_W-1];
         req_in[a][0].num_mag = n1[NUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1);
         req_in[a][0].den_mag = dmag;
         req_in[a][1].neg     = n2[NUM_W-1] ^ d_ff[a][D_W-1];
         req_in[a][1].num_mag = n2[NUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2);
         req_in[a][1].den_mag = dmag;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      dz_ff  <= dz_in;
      out_ff <= out_in;
      ts4_ff <= ts3_ff;
      te4_ff <= te3_ff;
   end

   // Entry and exit parameters for each axis
   for (genvar a = 0; a < 3; a++) begin : g_axis
      for (genvar b = 0; b < 2; b++) begin : g_bound
         ros_div u_div (
            .clock (clock),
            .req   (req_ff[a][b]),
            .quot  (quot[a][b])
         );
      end
   end

   // Hold item state alongside the dividers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LATENCY; i++) line_ff[i].valid <= 1'b0;
      end else begin
         line_ff[0].valid <= v4_ff;
         for (int i = 1; i < DIV_LATENCY; i++) line_ff[i].valid <= line_ff[i-1].valid;
      end
      line_ff[0].t_start <= ts4_ff;
      line_ff[0].t_end   <= te4_ff;
      line_ff[0].dzero   <= dz_ff;
      line_ff[0].outside <= out_ff;
      for (int i = 1; i < DIV_LATENCY; i++) begin
         line_ff[i].t_start <= line_ff[i-1].t_start;
         line_ff[i].t_end   <= line_ff[i-1].t_end;
         line_ff[i].dzero   <= line_ff[i-1].dzero;
         line_ff[i].outside <= line_ff[i-1].outside;
      end
   end

   // Order the two bounds of each axis
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff[0].valid <= 1'b0;
      end else begin
         st_ff[0].valid <= line_ff[DIV_LATENCY-1].valid;
      end
      st_ff[0].hit     <= 1'b1;
      st_ff[0].tn      <= line_ff[DIV_LATENCY-1].t_start;
      st_ff[0].tf      <= line_ff[DIV_LATENCY-1].t_end;
      st_ff[0].dzero   <= line_ff[DIV_LATENCY-1].dzero;
      st_ff[0].outside <= line_ff[DIV_LATENCY-1].outside;
      for (int a = 0; a < 3; a++) begin
         if (quot[a][0] < quot[a][1]) begin
            st_ff[0].lo[a] <= quot[a][0];
            st_ff[0].hi[a] <= quot[a][1];
         end else begin
            st_ff[0].lo[a] <= quot[a][1];
            st_ff[0].hi[a] <= quot[a][0];
         end
      end
   end

   // Clip the interval one axis per stage; a miss freezes it
   for (genvar a = 0; a < 3; a++) begin : g_clip
      always_comb begin
         st_in[a+1] = st_ff[a];
         if (st_ff[a].hit) begin
            if (st_ff[a].dzero[a]) begin
               if (st_ff[a].outside[a]) st_in[a+1].hit = 1'b0;
            end else begin
               if ($signed(st_ff[a].lo[a]) > st_ff[a].tn) st_in[a+1].tn = st_ff[a].lo[a];
               if ($signed(st_ff[a].hi[a]) < st_ff[a].tf) st_in[a+1].tf = st_ff[a].hi[a];
               if (st_in[a+1].tn > st_in[a+1].tf) st_in[a+1].hit = 1'b0;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[a+1].valid <= 1'b0;
         end else begin
            st_ff[a+1].valid <= st_ff[a].valid;
         end
         st_ff[a+1].hit     <= st_in[a+1].hit;
         st_ff[a+1].tn      <= st_in[a+1].tn;
         st_ff[a+1].tf      <= st_in[a+1].tf;
         st_ff[a+1].dzero   <= st_in[a+1].dzero;
         st_ff[a+1].outside <= st_in[a+1].outside;
         st_ff[a+1].lo      <= st_in[a+1].lo;
         st_ff[a+1].hi      <= st_in[a+1].hi;
      end
   end

   // Result register; drop a hit on a reversed interval
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= st_ff[3].valid;
      end
      rsp_hit_ff <= st_ff[3].hit && !(st_ff[3].tn > st_ff[3].tf);
      rsp_tn_ff  <= st_ff[3].tn;
      rsp_tf_ff  <= st_ff[3].tf;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_hit     = rsp_hit_ff;
   assign rsp_t_enter = rsp_tn_ff;
   assign rsp_t_exit  = rsp_tf_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##TOTAL_LAT rsp_valid)
      else $error("accepted item did not produce a result on time");

   a_miss_sticks: assert property (@(posedge clock) disable iff (reset)
      (st_ff[1].valid && !st_ff[1].hit) |=> !st_ff[2].hit)
      else $error("miss on an earlier axis was cleared");

   a_hit_ordered: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_t_enter <= rsp_t_exit))
      else $error("hit reported on an empty interval");

endmodule
